/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the design files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition at one edge implies a condition at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/krsm_pkg.sv */
// ---------------------------------------------------------------------------
// krsm_pkg
// types and constants shared by the stream matcher and its window cells
// ---------------------------------------------------------------------------
package krsm_pkg;

   localparam int BYTE_W   = 8;
   localparam int HASH_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int CFG_W    = 6;
   localparam int PIDX_W   = 5;

   localparam logic [CFG_W-1:0] LEN_RESET = 6'd1;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEXT = 1'b1
   } cmd_type;

   // control broadcast to every window cell
   typedef struct packed {
      logic              shift_win;
      logic              shift_rev;
      logic [BYTE_W-1:0] text_byte;
      logic [BYTE_W-1:0] inject_byte;
   } cell_ctl_type;

endpackage

/* design/krsm_cell.sv */
// ---------------------------------------------------------------------------
// krsm_cell
// one window cell: text byte by age, aligned compare byte, pattern byte
// ---------------------------------------------------------------------------
module krsm_cell
   import krsm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic                inject_sel,
   input  logic                pat_we,
   input  logic [BYTE_W-1:0]   win_prev,
   input  logic [BYTE_W-1:0]   rev_next,
   output logic [BYTE_W-1:0]   win_out,
   output logic [BYTE_W-1:0]   rev_out,
   output logic                match_next
);

   logic [BYTE_W-1:0] win_ff;
   logic [BYTE_W-1:0] win_in;
   logic [BYTE_W-1:0] rev_ff;
   logic [BYTE_W-1:0] rev_in;
   logic [BYTE_W-1:0] pat_ff;

   // compare chain runs toward cell 0, fed at the cell of the last pattern byte
   assign rev_in     = inject_sel ? ctl.inject_byte : rev_next;
   assign win_in     = win_prev;
   assign match_next = (rev_in == pat_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         rev_ff <= '0;
      end else begin
         if (ctl.shift_win) begin
            win_ff <= win_in;
         end
         if (ctl.shift_rev) begin
            rev_ff <= rev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_ff <= ctl.text_byte;
      end
   end

   assign win_out = win_ff;
   assign rev_out = rev_ff;

endmodule

/* design/karp_rabin_stream_matcher.sv */
// ---------------------------------------------------------------------------
// karp_rabin_stream_matcher
// rolling-hash pattern matcher over a byte stream with exact window check
// ---------------------------------------------------------------------------
//
//   channel  ports                       direction  moves
//   req      req_valid / req_ready       in         load or text word
//   rsp      rsp_valid / rsp_ready       out        match word, one per text word
//   csr      csr_write_enable            in         pattern length, no wait
//
// - a load word gives no response word
// - a text word's response word sits in the output register from the next
//   cycle, so up to one word per cycle flows through
// - a full output register that is not taken stalls req_ready
// - after a csr write the compare chain is realigned from the text window,
//   with req_ready low while the sweep runs
// - reset (synchronous) clears window, hashes, count and the output valid;
//   pattern bytes stay undefined until loaded
//
`include "assert_macros.svh"

module karp_rabin_stream_matcher
   import krsm_pkg::*;
#(
   parameter int MAX_PATTERN = 32
)
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic [PIDX_W-1:0]    req_pattern_index,
   input  logic                 req_last_byte,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_match_found,
   output logic [COUNT_W-1:0]   rsp_match_position,
   // configuration
   input  logic                 csr_write_enable,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > CFG_W) ? $clog2(MAX_PATTERN + 1) : CFG_W;
   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_PATTERN - 1);

   // configuration and realignment sweep
   logic [CFG_W-1:0]   len_cfg_ff;
   logic               sweep_ff;
   logic               sweep_in;
   logic [IDX_W-1:0]   sweep_cnt_ff;
   logic [IDX_W-1:0]   sweep_cnt_in;

   // hash and count state
   logic [HASH_W-1:0]  pat_hash_ff;
   logic [HASH_W-1:0]  pat_hash_in;
   logic [HASH_W-1:0]  win_hash_ff;
   logic [HASH_W-1:0]  win_hash_in;
   logic [COUNT_W-1:0] text_count_ff;
   logic [COUNT_W-1:0] text_count_in;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_match_ff;
   logic               rsp_match_in;
   logic [COUNT_W-1:0] rsp_pos_ff;
   logic [COUNT_W-1:0] rsp_pos_in;

   // datapath
   logic [LEN_W-1:0]   len_ext;
   logic [LEN_W-1:0]   len_used;
   logic [LEN_W-1:0]   len_m1;
   logic               accept;
   logic               text_fire;
   logic               load_ok;
   logic [HASH_W-1:0]  leave_term;
   logic [HASH_W-1:0]  hash_base;
   logic [HASH_W-1:0]  hash_next;
   logic [COUNT_W-1:0] filled;
   logic               full;
   logic               all_eq;
   logic               hit;
   cell_ctl_type       ctl;
   logic [IDX_W-1:0]   sweep_src;

   logic [BYTE_W-1:0]  win_bus [MAX_PATTERN];
   logic [BYTE_W-1:0]  rev_bus [MAX_PATTERN];
   logic               eq_bus  [MAX_PATTERN];

   // pattern length in use, clamped to 1..MAX_PATTERN
   always_comb begin
      len_ext  = LEN_W'(len_cfg_ff);
      len_used = len_ext;
      if (len_ext == '0) begin
         len_used = LEN_W'(1);
      end else if (len_ext > LEN_W'(MAX_PATTERN)) begin
         len_used = LEN_W'(MAX_PATTERN);
      end
   end
   assign len_m1 = len_used - LEN_W'(1);

   // handshake
   assign req_ready = !sweep_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign text_fire = accept && (cmd_type'(req_command) == CMD_TEXT);
   assign load_ok   = accept && (cmd_type'(req_command) == CMD_LOAD)
                      && (32'(req_pattern_index) < 32'(MAX_PATTERN));

   // during a sweep the window is replayed oldest first into the compare chain
   assign sweep_src = LAST_CELL - sweep_cnt_ff;

   always_comb begin
      ctl.shift_win   = text_fire;
      ctl.shift_rev   = text_fire || sweep_ff;
      ctl.text_byte   = req_data_byte;
      ctl.inject_byte = sweep_ff ? win_bus[sweep_src] : req_data_byte;
   end

   // window cells
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [BYTE_W-1:0] prev_byte;
      logic [BYTE_W-1:0] next_byte;

      if (k == 0) begin : g_head
         assign prev_byte = req_data_byte;
      end else begin : g_body
         assign prev_byte = win_bus[k-1];
      end
      if (k == MAX_PATTERN - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_link
         assign next_byte = rev_bus[k+1];
      end

      krsm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .inject_sel (len_m1 == LEN_W'(k)),
         .pat_we     (load_ok && (32'(req_pattern_index) == 32'(k))),
         .win_prev   (prev_byte),
         .rev_next   (next_byte),
         .win_out    (win_bus[k]),
         .rev_out    (rev_bus[k]),
         .match_next (eq_bus[k])
      );
   end

   // exact check: every cell below the pattern length must agree
   always_comb begin
      all_eq = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if ((LEN_W'(k) < len_used) && !eq_bus[k]) begin
            all_eq = 1'b0;
         end
      end
   end

   // rolling hash: drop the leaving byte (weight 2^(m-1)), then shift in the new one
   // cell 0 of the compare chain holds the byte of age m-1
   assign leave_term = HASH_W'(rev_bus[0]) << len_m1;
   assign hash_base  = (text_count_ff >= COUNT_W'(len_used)) ? (win_hash_ff - leave_term)
                                                              : win_hash_ff;
   assign hash_next  = (hash_base << 1) + HASH_W'(req_data_byte);

   assign filled = text_count_ff + COUNT_W'(1);
   assign full   = (filled != '0) && (filled >= COUNT_W'(len_used));
   assign hit    = full && (hash_next == pat_hash_ff) && all_eq;

   always_comb begin
      pat_hash_in   = pat_hash_ff;
      win_hash_in   = win_hash_ff;
      text_count_in = text_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_pos_in    = rsp_pos_ff;
      sweep_in      = sweep_ff;
      sweep_cnt_in  = sweep_cnt_ff;

      if (load_ok) begin
         if (req_pattern_index == '0) begin
            pat_hash_in = HASH_W'(req_data_byte);
         end else begin
            pat_hash_in = (pat_hash_ff << 1) + HASH_W'(req_data_byte);
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (text_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_match_in  = hit;
         rsp_pos_in    = full ? (filled - COUNT_W'(len_used)) : '0;
         win_hash_in   = req_last_byte ? '0 : hash_next;
         text_count_in = req_last_byte ? '0 : filled;
      end

      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + IDX_W'(1);
         if (sweep_cnt_ff == LAST_CELL) begin
            sweep_in = 1'b0;
         end
      end
      if (csr_write_enable) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff    <= LEN_RESET;
         sweep_ff      <= 1'b0;
         sweep_cnt_ff  <= '0;
         pat_hash_ff   <= '0;
         win_hash_ff   <= '0;
         text_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            len_cfg_ff <= csr_write_data;
         end
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         pat_hash_ff   <= pat_hash_in;
         win_hash_ff   <= win_hash_in;
         text_count_ff <= text_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = rsp_match_ff;
   assign rsp_match_position = rsp_pos_ff;

   // a csr write always starts a realignment sweep
   `ASSERT_NEXT(a_csr_starts_sweep, clock, reset, csr_write_enable, sweep_ff,
                "csr write did not start the realignment sweep")

   // the sweep ends after the last cell has been fed
   `ASSERT_NEXT(a_sweep_ends, clock, reset,
                sweep_ff && (sweep_cnt_ff == LAST_CELL) && !csr_write_enable, !sweep_ff,
                "realignment sweep ran past the last cell")

   // every text word leaves a response word behind
   `ASSERT_NEXT(a_text_gives_rsp, clock, reset, text_fire, rsp_valid_ff,
                "text word produced no response word")

   // a load never creates a response word
   `ASSERT_NEXT(a_load_no_rsp, clock, reset,
                accept && (cmd_type'(req_command) == CMD_LOAD) && !rsp_valid_ff,
                !rsp_valid_ff,
                "load word produced a response word")

   // a reported match lies inside a full window
   `ASSERT_IMPLIES(a_match_full, clock, reset, text_fire && hit,
                   filled >= COUNT_W'(len_used),
                   "match reported before the window filled")

endmodule

/* sim/tb_karp_rabin_stream_matcher.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_karp_rabin_stream_matcher
// self-checking bench: drives load and text words and length writes, predicts one match word
// per text word with a local rolling-hash model, compares every field
// ---------------------------------------------------------------------------
module tb_karp_rabin_stream_matcher;
   import krsm_pkg::*;

   localparam int MAX_PAT        = 32;
   localparam int RANDOM_WORDS   = 850;
   localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles before giving up
   localparam int LOAD_SETTLE    = 4;      // a load word may still be in flight
   localparam int DRAIN_TAIL     = 8;      // output register latency plus margin

   // idle / stall percentages per traffic phase
   localparam int IDLE_SET  [4] = '{0, 61, 0, 23};
   localparam int STALL_SET [4] = '{0, 0, 61, 23};

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] pos;
   } match_rec_type;

   // -----------------------------------------------------------------------
   // match scoreboard: own copy of pattern, window, hashes and length
   // -----------------------------------------------------------------------
   class match_scoreboard;
      logic [BYTE_W-1:0]  pat_store [MAX_PAT];
      logic [BYTE_W-1:0]  win_bytes [MAX_PAT];
      logic [HASH_W-1:0]  pat_hash;
      logic [HASH_W-1:0]  win_hash;
      logic [COUNT_W-1:0] byte_count;
      logic [CFG_W-1:0]   len_reg;
      match_rec_type      due_q [$];
      int                 fail_count;

      function new();
         foreach (pat_store[i]) pat_store[i] = '0;
         foreach (win_bytes[i]) win_bytes[i] = '0;
         pat_hash   = '0;
         win_hash   = '0;
         byte_count = '0;
         len_reg    = LEN_RESET;
         fail_count = 0;
      endfunction

      function void set_length(logic [CFG_W-1:0] v);
         len_reg = v;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      // accepted request word: update state, queue the match word it causes
      function void note_word(cmd_type cmd, logic [BYTE_W-1:0] b,
                              logic [PIDX_W-1:0] idx, logic last);
         int unsigned        m;
         logic [HASH_W-1:0]  weight;
         logic [COUNT_W-1:0] filled;
         match_rec_type      rec;
         if (cmd == CMD_LOAD) begin
            pat_store[idx] = b;
            if (idx == 0) pat_hash = HASH_W'(b);
            else pat_hash = (pat_hash << 1) + HASH_W'(b);
            return;
         end
         m = 32'(len_reg);
         if (m < 1) m = 1;
         if (m > MAX_PAT) m = MAX_PAT;
         weight = HASH_W'(1) << (m - 1);
         // drop the leaving byte only once the window is full
         if (byte_count >= m)
            win_hash = ((win_hash - HASH_W'(win_bytes[m-1]) * weight) << 1) + HASH_W'(b);
         else
            win_hash = (win_hash << 1) + HASH_W'(b);
         for (int k = MAX_PAT - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
         win_bytes[0] = b;
         filled    = byte_count + 1;
         rec.found = 1'b0;
         rec.pos   = '0;
         if (filled != 0 && filled >= m) begin
            rec.pos = filled - m;
            if (win_hash == pat_hash) begin
               rec.found = 1'b1;
               for (int k = 0; k < m; k++)
                  if (pat_store[k] !== win_bytes[m-1-k]) rec.found = 1'b0;
            end
         end
         byte_count = filled;
         if (last) begin
            byte_count = '0;
            win_hash   = '0;
         end
         due_q.push_back(rec);
      endfunction

      // accepted response word: compare with the oldest expectation
      function void check_word(logic found, logic [COUNT_W-1:0] pos);
         match_rec_type want;
         if (due_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected match word, expected none, actual found %0b pos %0d",
                     $time, found, pos);
            return;
         end
         want = due_q.pop_front();
         if (found !== want.found) begin
            fail_count++;
            $display("%0t: match_found expected %0b actual %0b",
                     $time, want.found, found);
         end
         if (pos !== want.pos) begin
            fail_count++;
            $display("%0t: match_position expected %0d actual %0d",
                     $time, want.pos, pos);
         end
      endfunction
   endclass

   // -----------------------------------------------------------------------
   // block under test
   // -----------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_command;
   logic [BYTE_W-1:0]  req_data_byte;
   logic [PIDX_W-1:0]  req_pattern_index;
   logic               req_last_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_match_found;
   logic [COUNT_W-1:0] rsp_match_position;
   logic               csr_write_enable;
   logic [CFG_W-1:0]   csr_write_data;

   match_scoreboard sb;
   int              idle_pct;
   int              stall_pct;
   int              words_sent;
   int              quiet_cycles;
   logic [BYTE_W-1:0] pat [MAX_PAT];   // pattern the stimulus embeds in the text

   karp_rabin_stream_matcher #(.MAX_PATTERN(MAX_PAT)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_data_byte      (req_data_byte),
      .req_pattern_index  (req_pattern_index),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_position (rsp_match_position),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // receiver: ready drops at random according to the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // observe both handshakes at the edge; values read here are pre-edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_word(cmd_type'(req_command), req_data_byte, req_pattern_index,
                      req_last_byte);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_match_found, rsp_match_position);
      // watchdog: any accepted word restarts the count
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // driving tasks
   // -----------------------------------------------------------------------

   // one request word; returns at the edge where it is accepted, valid still high
   task automatic send_word(input cmd_type cmd, input logic [BYTE_W-1:0] b,
                            input logic [PIDX_W-1:0] idx, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_data_byte     <= b;
      req_pattern_index <= idx;
      req_last_byte     <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // sender holds off until every match word has come back
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // length writes only with the block idle; the realign after it shows up as
   // req_ready low, which send_word simply waits out
   task automatic write_length(input logic [CFG_W-1:0] v);
      drain_words();
      repeat (LOAD_SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_length(v);
   endtask

   // byte source: full range, two letters (dense matches) or the two extremes
   function automatic logic [BYTE_W-1:0] pick_byte(int unsigned kind);
      case (kind)
         0: return BYTE_W'($urandom);
         1: return 8'h61 + BYTE_W'($urandom_range(1));
         default: return $urandom_range(1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   // -----------------------------------------------------------------------
   // directed corner cases
   // -----------------------------------------------------------------------
   task automatic run_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // length one after reset; top index load, last flag on a load is ignored
      send_word(CMD_LOAD, 8'h00, 5'd31, 1'b1);
      send_word(CMD_LOAD, 8'hFF, 5'd0, 1'b1);
      send_word(CMD_TEXT, 8'h00, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'hFF, 5'd31, 1'b0);
      // end of text: count and window hash restart after this word
      send_word(CMD_TEXT, 8'hFF, 5'd0, 1'b1);
      send_word(CMD_TEXT, 8'hFF, 5'd0, 1'b0);
      // a length of zero behaves as one
      write_length(6'd0);
      send_word(CMD_TEXT, 8'hFF, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h00, 5'd0, 1'b1);
      // hash collision: pattern 01 02 and text 00 04 both hash to 4
      write_length(6'd2);
      send_word(CMD_LOAD, 8'h01, 5'd0, 1'b0);
      send_word(CMD_LOAD, 8'h02, 5'd1, 1'b0);
      send_word(CMD_TEXT, 8'h00, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h04, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h01, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h02, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h01, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h02, 5'd0, 1'b1);
      // loads out of order: index 0 restarts the hash, so the match is hidden
      send_word(CMD_LOAD, 8'h55, 5'd1, 1'b0);
      send_word(CMD_LOAD, 8'hAA, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'hAA, 5'd0, 1'b0);
      send_word(CMD_TEXT, 8'h55, 5'd0, 1'b1);
   endtask

   // -----------------------------------------------------------------------
   // random phases: load a pattern, stream text that embeds copies of it
   // -----------------------------------------------------------------------
   task automatic run_random();
      int unsigned      phase;
      int unsigned      m;
      int unsigned      n;
      int unsigned      copy_left;
      int unsigned      kind;
      logic [CFG_W-1:0] len_val;
      logic [BYTE_W-1:0] b;
      logic             last;
      phase      = 0;
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         idle_pct  = IDLE_SET[phase % 4];
         stall_pct = STALL_SET[phase % 4];
         case ($urandom_range(9))
            0: len_val = 6'd0;
            1: len_val = 6'd32;
            2: len_val = $urandom_range(1) ? 6'd63 : CFG_W'($urandom_range(33, 62));
            default: len_val = CFG_W'($urandom_range(1, 8));
         endcase
         // length the block will actually use
         m = (len_val == 0) ? 1 : ((len_val > MAX_PAT) ? MAX_PAT : 32'(len_val));
         kind = $urandom_range(2);
         for (int i = 0; i < m; i++) pat[i] = pick_byte(kind);
         write_length(len_val);
         // every entry in use is written before any text can read it
         for (int i = 0; i < m; i++)
            send_word(CMD_LOAD, pat[i], PIDX_W'(i), 1'($urandom_range(1)));
         // now and then a stray reload: stale hash, matches may be hidden
         if ($urandom_range(7) == 0)
            send_word(CMD_LOAD, pick_byte(kind), PIDX_W'($urandom_range(m - 1)),
                      1'($urandom_range(1)));
         n         = $urandom_range(8, 40);
         copy_left = 0;
         for (int j = 0; j < n; j++) begin
            if (copy_left == 0 && $urandom_range(2) == 0) copy_left = m;
            if (copy_left > 0) begin
               b = pat[m - copy_left];
               copy_left--;
            end else begin
               b = pick_byte(kind);
            end
            last = (j == n - 1) ? ($urandom_range(3) != 0) : ($urandom_range(39) == 0);
            // index field is don't-care on text, so it carries noise
            send_word(CMD_TEXT, b, PIDX_W'($urandom), last);
            // length change in the middle of a text, only to lengths already loaded
            if (j == n / 2 && $urandom_range(5) == 0) begin
               len_val   = CFG_W'($urandom_range(1, m));
               m         = 32'(len_val);
               copy_left = 0;
               write_length(len_val);
            end else if ($urandom_range(40) == 0) begin
               drain_words();
            end
         end
         phase++;
      end
   endtask

   // -----------------------------------------------------------------------
   // main sequence
   // -----------------------------------------------------------------------
   initial begin
      sb                = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_LOAD;
      req_data_byte     = '0;
      req_pattern_index = '0;
      req_last_byte     = 1'b0;
      rsp_ready         = 1'b0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      idle_pct          = 0;
      stall_pct         = 0;
      words_sent        = 0;
      quiet_cycles      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      // everything sent: wait for the last match words, then a short tail
      drain_words();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
